// ===== hw/rtl/ita_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types
// for the integer to ASCII formatter. No dependencies.
package ita_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_WIDTH  = 63;

    // field widths of width/room
    localparam int FLD_W = 6;

    // decimal digits needed for VALUE_BITS (floor(log10(2^n)) + 1)
    localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int DIG_BITS   = 4 * NUM_DIGITS;
    localparam int DIG_IW     = $clog2(NUM_DIGITS);

    // binary to BCD, two bits per cycle
    localparam int DD_STEPS = (VALUE_BITS + 1) / 2;
    localparam int DD_BITS  = 2 * DD_STEPS;
    localparam int STEP_W   = $clog2(DD_STEPS);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic load;
        logic conv;
        logic size;
        logic emit;
    } ita_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } ita_sts_t;

endpackage

// ===== hw/rtl/ita_ctrl.sv =====
// Sequencing state machine for the formatter: load, convert, size, emit.
// Depends on ita_pkg.
module ita_ctrl
    import ita_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output ita_cmd_t cmd,
    input  ita_sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DD_STEPS - 1)) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (sts.out_free && sts.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hw/rtl/ita_datapath.sv =====
// Formatter datapath: operand registers, binary to BCD converter, field
// sizing, character selection and the output word register. Uses ita_pkg.
module ita_datapath
    import ita_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ita_cmd_t    cmd,
    output ita_sts_t    sts,
    input  logic [31:0] value,
    input  logic        signed_mode,
    input  logic        hex_mode,
    input  logic [5:0]  width,
    input  logic        zero_pad,
    input  logic [5:0]  room,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  char_out,
    output logic        empty_res,
    output logic        last
);

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    function automatic digits_t dd_step(input digits_t d, input logic b);
        digits_t a;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            a[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
        end
        return digits_t'({a, b});
    endfunction

    logic [DD_BITS-1:0] mag_reg;
    digits_t            bcd_reg;
    logic               neg_reg, hex_reg, zp_reg;
    logic [FLD_W-1:0]   w_reg, room_reg;
    logic [FLD_W-1:0]   len_reg, cnt_reg, pad_reg, dstart_reg, k_reg;
    logic               out_valid_reg, out_empty_reg, out_last_reg;
    logic [7:0]         out_char_reg;

    logic [VALUE_BITS-1:0] v;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [FLD_W-1:0]      w_sat;
    digits_t               bcd_one, bcd_two;
    logic [FLD_W-1:0]      nd, total, len_c, cnt_c;
    logic [FLD_W-1:0]      dig_pos;
    logic [3:0]            dig;
    logic [7:0]            dig_ch, ch;
    logic                  load_out;

    assign v      = value[VALUE_BITS-1:0];
    assign neg_in = signed_mode && !hex_mode && v[VALUE_BITS-1];
    assign mag_in = neg_in ? (~v + 1'b1) : v;
    assign w_sat  = (width > FLD_W'(MAX_WIDTH)) ? FLD_W'(MAX_WIDTH) : width;

    assign bcd_one = dd_step(bcd_reg, mag_reg[DD_BITS-1]);
    assign bcd_two = dd_step(bcd_one, mag_reg[DD_BITS-2]);

    always_comb begin
        nd = FLD_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                nd = FLD_W'(i + 1);
            end
        end
    end

    assign total = nd + FLD_W'(neg_reg);
    assign len_c = (w_reg > total) ? w_reg : total;
    assign cnt_c = (room_reg == '0) ? FLD_W'(1) :
                   (len_c > room_reg) ? room_reg : len_c;

    assign dig_pos = len_reg - k_reg - FLD_W'(1);
    assign dig     = (dig_pos < FLD_W'(NUM_DIGITS)) ? bcd_reg[dig_pos[DIG_IW-1:0]] : 4'd0;
    assign dig_ch  = (dig < 4'd10) ? CH_ZERO + {4'd0, dig} : CH_A - 8'd10 + {4'd0, dig};

    always_comb begin
        ch = dig_ch;
        if (room_reg == '0) begin
            ch = CH_NUL;
        end else if (!zp_reg) begin
            if (k_reg < pad_reg) begin
                ch = CH_SPACE;
            end else if (neg_reg && k_reg == pad_reg) begin
                ch = CH_MINUS;
            end
        end else begin
            if (neg_reg && k_reg == '0) begin
                ch = CH_MINUS;
            end else if (k_reg < dstart_reg) begin
                ch = CH_ZERO;
            end
        end
    end

    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.emit_last = (k_reg == cnt_reg - FLD_W'(1));
    assign load_out      = cmd.emit && sts.out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg  <= DD_BITS'(mag_in);
            bcd_reg  <= hex_mode ? digits_t'(v) : '0;
            neg_reg  <= neg_in;
            hex_reg  <= hex_mode;
            zp_reg   <= zero_pad;
            w_reg    <= w_sat;
            room_reg <= room;
        end else if (cmd.conv && !hex_reg) begin
            mag_reg <= mag_reg << 2;
            bcd_reg <= bcd_two;
        end
        if (cmd.size) begin
            len_reg    <= len_c;
            cnt_reg    <= cnt_c;
            pad_reg    <= len_c - total;
            dstart_reg <= len_c - nd;
            k_reg      <= '0;
        end else if (load_out) begin
            k_reg <= k_reg + FLD_W'(1);
        end
        if (load_out) begin
            out_char_reg  <= ch;
            out_empty_reg <= (room_reg == '0);
            out_last_reg  <= sts.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign char_out  = out_char_reg;
    assign empty_res = out_empty_reg;
    assign last      = out_last_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter, top level: stream ports, controller and
// datapath. Depends on ita_pkg, ita_ctrl and ita_datapath.
//
// Usage: each input word carries a 32-bit operand, its signed/hex flags,
// a minimum field width, a zero-pad flag and a character budget. The block
// returns the formatted text one character per output word, most
// significant first, with m_tlast on the final character. A budget of zero
// gives one word with m_tuser set and a NUL character.
// Timing: the operand is loaded at acceptance, then converted from binary to
// BCD two bits per cycle (hex items also pass through these conversion steps),
// then the field is sized, then one character per cycle unless m_tready stalls.
// A new item is taken once the last character sits in the output register.
// Reset (aresetn low, synchronous) returns to idle and drops m_tvalid.
// A stall on m_tready holds the output word and pauses the character stream.
module integer_to_ascii_formatter
    import ita_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[31:0], width[37:32], zero_pad[38], room[44:39]
    input  logic [1:0]  s_tuser,   // signed_mode[0], hex_mode[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out[7:0]
    output logic        m_tuser,   // empty_res
    output logic        m_tlast
);

    ita_cmd_t cmd;
    ita_sts_t sts;

    ita_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ita_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .value       (s_tdata[31:0]),
        .signed_mode (s_tuser[0]),
        .hex_mode    (s_tuser[1]),
        .width       (s_tdata[37:32]),
        .zero_pad    (s_tdata[38]),
        .room        (s_tdata[44:39]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .char_out    (m_tdata),
        .empty_res   (m_tuser),
        .last        (m_tlast)
    );

endmodule

// ===== hw/rtl/ita_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to the top
// level. Depends on integer_to_ascii_formatter.
module ita_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'h00)
        else $error("empty word not final or not NUL");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !(m_tvalid && !$past(m_tvalid)))
        else $error("accepted while busy or early output");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state not cleared by reset");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);

// ===== tb/sv/tb_integer_to_ascii_formatter.sv =====
// Self-checking testbench for integer_to_ascii_formatter: a directed table,
// then random items; each output word is checked against the table's text or a local text predictor.
// Depends on ita_pkg and the integer_to_ascii_formatter RTL.
module tb_integer_to_ascii_formatter;
    import ita_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        sgn;
        logic        hex;
        logic [5:0]  width;
        logic        zp;
        logic [5:0]  room;
    } fmt_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       empty;
        logic       last;
    } char_word_t;

    typedef struct {
        fmt_item_t item;
        bit        typed;
        string     text;
    } dir_row_t;

    localparam int DIR_ROWS    = 22;
    localparam int RAND_ITEMS  = 248;
    localparam int CALM_ITEMS  = 40;
    localparam int HOLD_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    char_word_t chars_due[$];
    int         char_errors = 0;
    bit         idle_on = 1'b1;
    bit         hold_req = 1'b0;
    dir_row_t   dir_rows[DIR_ROWS];

    integer_to_ascii_formatter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // expected characters of one item, most significant first
    function automatic void predict_text(input fmt_item_t it);
        logic [31:0]  mag;
        logic         neg;
        logic [4:0]   base;
        logic [3:0]   dig;
        byte unsigned digits[$];
        byte unsigned text[$];
        int           wid;
        int           total;
        int           n;
        int           k;
        neg  = it.sgn && !it.hex && it.value[31];
        mag  = neg ? -it.value : it.value;
        base = it.hex ? 5'd16 : 5'd10;
        do begin
            dig = 4'(mag % base);
            digits.push_front((dig < 4'd10) ? CH_ZERO + 8'(dig) : CH_A - 8'd10 + 8'(dig));
            mag = mag / base;
        end while (mag != 0);
        wid   = (it.width > MAX_WIDTH) ? MAX_WIDTH : it.width;
        total = digits.size() + (neg ? 1 : 0);
        if (!it.zp)
            for (k = 0; k < wid - total; k++)
                text.push_back(CH_SPACE);
        if (neg)
            text.push_back(CH_MINUS);
        if (it.zp)
            for (k = 0; k < wid - total; k++)
                text.push_back(CH_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
        if (it.room == 0) begin
            chars_due.push_back('{CH_NUL, 1'b1, 1'b1});
        end else begin
            n = (text.size() > it.room) ? it.room : text.size();
            for (k = 0; k < n; k++)
                chars_due.push_back('{text[k], 1'b0, k == n - 1});
        end
    endfunction

    function automatic fmt_item_t rand_item();
        fmt_item_t it;
        case ($urandom_range(0, 3))
            0: it.value = $urandom;
            1: it.value = $urandom_range(0, 999);
            2: it.value = -$urandom_range(1, 100000);
            default: it.value = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)
                                ^ $urandom_range(0, 15);
        endcase
        it.sgn   = 1'($urandom_range(0, 1));
        it.hex   = 1'($urandom_range(0, 1));
        it.zp    = 1'($urandom_range(0, 1));
        it.width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(15, 63))
                                               : 6'($urandom_range(0, 14));
        case ($urandom_range(0, 7))
            0: it.room = 6'd0;
            1, 2: it.room = 6'($urandom_range(1, 12));
            3: it.room = 6'd63;
            default: it.room = 6'($urandom_range(0, 63));
        endcase
        return it;
    endfunction

    task automatic send_item(input fmt_item_t it, input bit typed, input string text);
        int gap;
        int k;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.room, it.zp, it.width, it.value};
        s_tuser  <= {it.hex, it.sgn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!typed)
            predict_text(it);
        else if (text.len() == 0)
            chars_due.push_back('{CH_NUL, 1'b1, 1'b1});
        else
            for (k = 0; k < text.len(); k++)
                chars_due.push_back('{text[k], 1'b0, k == text.len() - 1});
    endtask

    // output word check
    always @(posedge aclk) begin
        char_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (chars_due.size() == 0) begin
                if (char_errors < 10)
                    $display("unexpected word: char %h empty %b last %b",
                             m_tdata, m_tuser, m_tlast);
                char_errors++;
            end else begin
                want = chars_due.pop_front();
                if (m_tdata !== want.ch || m_tuser !== want.empty || m_tlast !== want.last) begin
                    if (char_errors < 10)
                        $display("word mismatch: want char %h empty %b last %b, got %h %b %b",
                                 want.ch, want.empty, want.last, m_tdata, m_tuser, m_tlast);
                    char_errors++;
                end
            end
        end
    end

    // receiver ready, with random stalls and one long hold-off
    initial begin : ready_drive
        int stall;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #8000000;
        $display("integer_to_ascii_formatter verification failed");
        $finish;
    end

    initial begin
        dir_rows = '{
            '{'{32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0, 6'd63}, 1'b1, "0"},
            '{'{32'hffff_ffff, 1'b0, 1'b0, 6'd0,  1'b0, 6'd63}, 1'b1, "4294967295"},
            '{'{32'hffff_ffff, 1'b1, 1'b0, 6'd0,  1'b0, 6'd63}, 1'b1, "-1"},
            '{'{32'h8000_0000, 1'b1, 1'b0, 6'd0,  1'b0, 6'd63}, 1'b1, "-2147483648"},
            '{'{32'h7fff_ffff, 1'b1, 1'b0, 6'd0,  1'b0, 6'd63}, 1'b1, "2147483647"},
            '{'{32'hffff_ffff, 1'b1, 1'b1, 6'd0,  1'b0, 6'd63}, 1'b1, "ffffffff"},
            '{'{32'h8000_0000, 1'b1, 1'b1, 6'd0,  1'b0, 6'd63}, 1'b1, "80000000"},
            '{'{32'h0000_1234, 1'b0, 1'b0, 6'd5,  1'b1, 6'd0},  1'b1, ""},
            '{'{32'h0000_0000, 1'b1, 1'b1, 6'd63, 1'b1, 6'd0},  1'b1, ""},
            '{'{32'hffff_ffff, 1'b0, 1'b0, 6'd0,  1'b0, 6'd3},  1'b1, "429"},
            '{'{32'hffff_ffd6, 1'b1, 1'b0, 6'd0,  1'b0, 6'd1},  1'b1, "-"},
            '{'{32'hdead_beef, 1'b0, 1'b1, 6'd12, 1'b1, 6'd63}, 1'b0, ""},
            '{'{32'hffff_ffd6, 1'b1, 1'b0, 6'd8,  1'b0, 6'd63}, 1'b0, ""},
            '{'{32'hffff_ffd6, 1'b1, 1'b0, 6'd8,  1'b1, 6'd63}, 1'b0, ""},
            '{'{32'h0000_0005, 1'b0, 1'b0, 6'd63, 1'b0, 6'd63}, 1'b0, ""},
            '{'{32'h8000_0000, 1'b1, 1'b0, 6'd63, 1'b1, 6'd63}, 1'b0, ""},
            '{'{32'h0000_0007, 1'b0, 1'b0, 6'd20, 1'b0, 6'd5},  1'b0, ""},
            '{'{32'h0123_abcd, 1'b0, 1'b1, 6'd0,  1'b0, 6'd63}, 1'b0, ""},
            '{'{32'h0000_0000, 1'b0, 1'b1, 6'd4,  1'b1, 6'd63}, 1'b0, ""},
            '{'{32'h7fff_ffff, 1'b0, 1'b1, 6'd63, 1'b0, 6'd10}, 1'b0, ""},
            '{'{32'h0000_3039, 1'b0, 1'b0, 6'd3,  1'b0, 6'd63}, 1'b0, ""},
            '{'{32'h0000_0001, 1'b1, 1'b0, 6'd42, 1'b1, 6'd42}, 1'b0, ""}
        };
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].text);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 60)
                hold_req = 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            send_item(rand_item(), 1'b0, "");
        end
        s_tvalid <= 1'b0;

        while (chars_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (char_errors == 0 && chars_due.size() == 0)
            $display("integer_to_ascii_formatter verification clean");
        else
            $display("integer_to_ascii_formatter verification failed");
        $finish;
    end

endmodule
